@@ rtl/alhd_pkg.sv @@
package alhd_pkg;

    localparam int HDR_LEN    = 14;
    localparam int DIGITS     = 10;
    // Only the low digits can carry a length that passes the size check; any
    // nonzero digit above them already exceeds the largest allowed payload.
    localparam int LOW_DIGITS = 5;
    localparam int VAL_W      = 17;
    localparam int FILL_W     = 4;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HDR_LEN - 1);

    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic [LOW_DIGITS-1:0][VAL_W-1:0] POW10 = {
        17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
    };

    typedef logic [7:0] byte_t;
    typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2
    } kind_t;

    typedef struct packed {
        logic match;
        logic oversize;
        logic empty;
    } hdr_status_t;

endpackage

@@ rtl/alhd_hdr_parse.sv @@
module alhd_hdr_parse #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int LEN_W       = 11
) (
    input  alhd_pkg::hdr_bytes_t  hdr,
    output alhd_pkg::hdr_status_t status,
    output logic [LEN_W-1:0]      length
);
    import alhd_pkg::*;

    logic             frame_ok;
    logic             digits_ok;
    logic             high_nonzero;
    logic [VAL_W-1:0] value;
    byte_t            ch;

    assign frame_ok = (hdr[0] == CH_OPEN) && (hdr[1] == CH_CARET) &&
                      (hdr[HDR_LEN-2] == CH_CARET) && (hdr[HDR_LEN-1] == CH_CLOSE);

    always_comb begin
        digits_ok    = 1'b1;
        high_nonzero = 1'b0;
        value        = '0;
        for (int i = 0; i < DIGITS; i++) begin
            ch = hdr[2 + i];
            if (ch < CH_ZERO || ch > CH_NINE) begin
                digits_ok = 1'b0;
            end
            // For a digit character the low nibble is the digit value.
            if (i < DIGITS - LOW_DIGITS) begin
                if (ch[3:0] != 4'd0) begin
                    high_nonzero = 1'b1;
                end
            end else begin
                value = value + VAL_W'(ch[3:0]) * POW10[DIGITS - 1 - i];
            end
        end
    end

    assign status.match    = frame_ok && digits_ok;
    assign status.oversize = high_nonzero || (value > VAL_W'(MAX_PAYLOAD));
    assign status.empty    = !high_nonzero && (value == '0);
    assign length          = value[LEN_W-1:0];

endmodule

@@ rtl/ascii_length_header_deframer.sv @@
// Byte-stream deframer for frames that open with an ASCII length header:
// '<', '^', ten decimal length digits, '^', '>', then that many payload bytes.
// Input channel: one received byte per request on s_valid/s_ready/s_rx_byte.
// Result channel: m_valid/m_ready with m_kind (payload byte, empty frame or
// oversize header dropped), m_payload_byte and m_last on the final payload
// byte. Header bytes and mismatching windows give no result; a header with
// a length above MAX_PAYLOAD gives one oversize result and is discarded.
// Each byte is handled as it is taken: the header check and decimal parse sit
// between the state registers and the output register, so a result appears
// in the cycle after its byte is taken. Throughput is one byte per cycle while
// m_ready is high. When the receiver stalls, the output register holds its
// result and s_ready drops until that result is taken; bytes that give no
// result still need a free output slot to enter.
// Reset (aresetn low, synchronous) empties the header window, returns the
// block to header hunt and clears the output valid.
module ascii_length_header_deframer #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_payload_byte,
    output logic       m_last
);
    import alhd_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    logic [HDR_LEN-2:0][7:0] win_reg, win_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic                    in_payload_reg, in_payload_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic                    m_valid_reg, m_valid_next;
    kind_t                   kind_reg, kind_next;
    byte_t                   byte_reg, byte_next;
    logic                    last_reg, last_next;

    logic                    accept;
    hdr_bytes_t              hdr;
    hdr_status_t             status;
    logic [LEN_W-1:0]        length;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < HDR_LEN - 1; i++) begin
            hdr[i] = win_reg[i];
        end
        hdr[HDR_LEN-1] = s_rx_byte;
    end

    alhd_hdr_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W)
    ) u_hdr_parse (
        .hdr    (hdr),
        .status (status),
        .length (length)
    );

    always_comb begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        rem_next        = rem_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;

        if (accept) begin
            if (in_payload_reg) begin
                rem_next     = rem_reg - LEN_W'(1);
                m_valid_next = 1'b1;
                kind_next    = KIND_PAYLOAD;
                byte_next    = s_rx_byte;
                last_next    = (rem_reg == LEN_W'(1));
                if (rem_reg == LEN_W'(1)) begin
                    in_payload_next = 1'b0;
                end
            end else begin
                // The window always shifts; the fill count says how much of it
                // has been written since it was last emptied.
                for (int i = 0; i < HDR_LEN - 2; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[HDR_LEN-2] = s_rx_byte;

                if (fill_reg != FILL_FULL) begin
                    fill_next = fill_reg + FILL_W'(1);
                end else if (status.match) begin
                    fill_next = '0;
                    if (status.oversize) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_OVERSIZE;
                        byte_next    = '0;
                        last_next    = 1'b0;
                    end else if (status.empty) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_EMPTY;
                        byte_next    = '0;
                        last_next    = 1'b0;
                    end else begin
                        in_payload_next = 1'b1;
                        rem_next        = length;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            rem_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            rem_reg        <= rem_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_payload_byte = byte_reg;
    assign m_last         = last_reg;

    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (rem_reg != '0))
        else $error("payload mode with no bytes remaining");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("window fill count out of range");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_payload_reg && rem_reg == LEN_W'(1)) |=>
            (!in_payload_reg && m_valid_reg && last_reg))
        else $error("final payload byte did not end the frame");

    a_non_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg != KIND_PAYLOAD) |-> (!last_reg && byte_reg == '0))
        else $error("non-payload result carries data");

endmodule
